// File: hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes shared by the first-fit block allocator and its cells.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // working width for sizes and offsets (covers 16-bit requests plus header)
   localparam int CW = 17;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_OVER    = 3'd1;
   localparam logic [2:0] ST_NOFIT   = 3'd2;
   localparam logic [2:0] ST_BADADDR = 3'd3;
   localparam logic [2:0] ST_DOUBLE  = 3'd4;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] req_size;
      logic [12:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] block_offset;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_MATCH   = 3'd1,
      OP_USE     = 3'd2,
      OP_SPLIT   = 3'd3,
      OP_RELEASE = 3'd4,
      OP_JOIN    = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type   op;
      logic          mode;
      logic [CW-1:0] size;
      logic [CW-1:0] addr;
      logic [CW-1:0] new_start;
      logic [CW-1:0] new_bytes;
   } cell_cmd_type;

endpackage

// File: hw/rtl/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One block table entry; shifts to/from its neighbors on split and join.
// ----------------------------------------------------------------------------
module ffba_cell #(
   parameter int DW           = 13,
   parameter int HEADER_BYTES = 32,
   parameter int RESET_BYTES  = 4064,
   parameter bit IS_FIRST     = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffba_pkg::cell_cmd_type cmd,
   input  logic                   at_i,
   input  logic                   prev_at_i,
   input  logic                   above_i,
   output logic                   above_o,
   input  logic                   seen_i,
   output logic                   seen_o,
   output logic                   hit_o,
   input  logic [DW-1:0]          prev_start_i,
   input  logic [DW-1:0]          prev_bytes_i,
   input  logic                   prev_free_i,
   input  logic                   prev_valid_i,
   input  logic [DW-1:0]          next_start_i,
   input  logic [DW-1:0]          next_bytes_i,
   input  logic                   next_free_i,
   input  logic                   next_valid_i,
   output logic [DW-1:0]          start_o,
   output logic [DW-1:0]          bytes_o,
   output logic                   free_o,
   output logic                   valid_o
);
   import ffba_pkg::*;

   logic [DW-1:0] start_ff, start_in;
   logic [DW-1:0] bytes_ff, bytes_in;
   logic          free_ff, free_in;
   logic          valid_ff, valid_in;
   logic          match_ff, match_in;

   always_comb begin
      start_in = start_ff;
      bytes_in = bytes_ff;
      free_in  = free_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      case (cmd.op)
         OP_MATCH: begin
            if (cmd.mode == MODE_ALLOC) begin
               match_in = valid_ff && free_ff && (CW'(bytes_ff) >= cmd.size);
            end else begin
               match_in = valid_ff && (CW'(start_ff) == cmd.addr);
            end
         end
         OP_USE: begin
            if (at_i) begin
               free_in = 1'b0;
            end
         end
         OP_SPLIT: begin
            if (at_i) begin
               bytes_in = cmd.size[DW-1:0];
               free_in  = 1'b0;
            end else if (prev_at_i) begin
               start_in = cmd.new_start[DW-1:0];
               bytes_in = cmd.new_bytes[DW-1:0];
               free_in  = 1'b1;
               valid_in = 1'b1;
            end else if (above_i) begin
               start_in = prev_start_i;
               bytes_in = prev_bytes_i;
               free_in  = prev_free_i;
               valid_in = prev_valid_i;
            end
         end
         OP_RELEASE: begin
            if (at_i) begin
               free_in = 1'b1;
            end
         end
         OP_JOIN: begin
            if (at_i) begin
               bytes_in = bytes_ff + next_bytes_i + DW'(HEADER_BYTES);
            end else if (above_i) begin
               start_in = next_start_i;
               bytes_in = next_bytes_i;
               free_in  = next_free_i;
               valid_in = next_valid_i;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         bytes_ff <= DW'(RESET_BYTES);
         free_ff  <= 1'b1;
         valid_ff <= IS_FIRST;
         match_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
         bytes_ff <= bytes_in;
         free_ff  <= free_in;
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   assign above_o = above_i | at_i;
   assign hit_o   = match_ff & ~seen_i;
   assign seen_o  = seen_i | match_ff;
   assign start_o = start_ff;
   assign bytes_o = bytes_ff;
   assign free_o  = free_ff;
   assign valid_o = valid_ff;

endmodule

// File: hw/rtl/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over an address-ordered block table held in a chain of
// cells, with splitting on allocate and coalescing of free neighbors.
// ----------------------------------------------------------------------------
// Steps: an allocate or a rejected free passes through the match, pick and
//   act steps of the cell chain before the result strobe; an accepted free
//   adds the prev and next merge steps, plus a join step when the freed block
//   merges with its previous neighbor; busy drops the cycle after the strobe.
// A new request is taken only after busy drops, so requests never overlap.
// Reset: one free block spanning the whole pool; table holds one entry.
// The receiver cannot stall; each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
   parameter int POOL_BYTES   = 4096,
   parameter int HEADER_BYTES = 32,
   parameter int MAX_ENTRIES  = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffba_pkg::req_type req_item,
   output logic              rsp_valid,
   output ffba_pkg::rsp_type rsp_item
);
   import ffba_pkg::*;

   // stored offsets/sizes need to reach POOL_BYTES itself
   localparam int DW    = $clog2(POOL_BYTES) + 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int N     = MAX_ENTRIES;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MATCH = 7'b0000010,
      S_PICK  = 7'b0000100,
      S_ACT   = 7'b0001000,
      S_PREV  = 7'b0010000,
      S_JOINP = 7'b0100000,
      S_NEXT  = 7'b1000000
   } state_type;

   state_type      state_ff, state_in;
   req_type        req_ff, req_in;
   logic [N-1:0]   sel_ff, sel_in;
   logic           found_ff, found_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic           done_ff, done_in;
   rsp_type        rsp_ff, rsp_in;

   cell_cmd_type   cmd;

   // cell chain wires
   logic [N-1:0]   hit;
   logic [N:0]     above_c;
   logic [N:0]     seen_c;
   logic [DW-1:0]  c_start [N];
   logic [DW-1:0]  c_bytes [N];
   logic [N-1:0]   c_free;
   logic [N-1:0]   c_valid;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         logic [DW-1:0] p_start, p_bytes, n_start, n_bytes;
         logic          p_free, p_valid, n_free, n_valid, p_at;
         if (g == 0) begin : g_head
            assign p_start = '0;
            assign p_bytes = '0;
            assign p_free  = 1'b0;
            assign p_valid = 1'b0;
            assign p_at    = 1'b0;
         end else begin : g_mid
            assign p_start = c_start[g-1];
            assign p_bytes = c_bytes[g-1];
            assign p_free  = c_free[g-1];
            assign p_valid = c_valid[g-1];
            assign p_at    = sel_ff[g-1];
         end
         if (g == N - 1) begin : g_tail
            assign n_start = '0;
            assign n_bytes = '0;
            assign n_free  = 1'b0;
            assign n_valid = 1'b0;
         end else begin : g_body
            assign n_start = c_start[g+1];
            assign n_bytes = c_bytes[g+1];
            assign n_free  = c_free[g+1];
            assign n_valid = c_valid[g+1];
         end
         ffba_cell #(
            .DW           (DW),
            .HEADER_BYTES (HEADER_BYTES),
            .RESET_BYTES  (POOL_BYTES - HEADER_BYTES),
            .IS_FIRST     (g == 0)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .cmd          (cmd),
            .at_i         (sel_ff[g]),
            .prev_at_i    (p_at),
            .above_i      (above_c[g]),
            .above_o      (above_c[g+1]),
            .seen_i       (seen_c[g]),
            .seen_o       (seen_c[g+1]),
            .hit_o        (hit[g]),
            .prev_start_i (p_start),
            .prev_bytes_i (p_bytes),
            .prev_free_i  (p_free),
            .prev_valid_i (p_valid),
            .next_start_i (n_start),
            .next_bytes_i (n_bytes),
            .next_free_i  (n_free),
            .next_valid_i (n_valid),
            .start_o      (c_start[g]),
            .bytes_o      (c_bytes[g]),
            .free_o       (c_free[g]),
            .valid_o      (c_valid[g])
         );
      end
   endgenerate

   assign above_c[0] = 1'b0;
   assign seen_c[0]  = 1'b0;

   // selected entry and its neighbors, one-hot AND-OR over the chain
   logic [DW-1:0] s_start, s_bytes;
   logic          s_free, pv_free, nx_free, nx_valid;

   always_comb begin
      s_start  = '0;
      s_bytes  = '0;
      s_free   = 1'b0;
      pv_free  = 1'b0;
      nx_free  = 1'b0;
      nx_valid = 1'b0;
      for (int j = 0; j < N; j++) begin
         s_start = s_start | ({DW{sel_ff[j]}} & c_start[j]);
         s_bytes = s_bytes | ({DW{sel_ff[j]}} & c_bytes[j]);
         s_free  = s_free  | (sel_ff[j] & c_free[j]);
         if (j > 0) begin
            pv_free = pv_free | (sel_ff[j] & c_free[j-1]);
         end
         if (j < N - 1) begin
            nx_free  = nx_free  | (sel_ff[j] & c_free[j+1]);
            nx_valid = nx_valid | (sel_ff[j] & c_valid[j+1]);
         end
      end
   end

   logic [CW-1:0] n_req, n_plus_h, sb_ext;
   assign n_req    = CW'(req_ff.req_size);
   assign n_plus_h = n_req + CW'(HEADER_BYTES);
   assign sb_ext   = CW'(s_bytes);

   logic addr_bad;
   assign addr_bad = (CW'(req_ff.free_addr) >= CW'(POOL_BYTES)) || !found_ff;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      sel_in   = sel_ff;
      found_in = found_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      rsp_in   = rsp_ff;
      cmd           = '0;
      cmd.op        = OP_NONE;
      cmd.mode      = req_ff.mode;
      cmd.size      = n_req;
      cmd.addr      = CW'(req_ff.free_addr);
      cmd.new_start = CW'(s_start) + n_plus_h;
      cmd.new_bytes = sb_ext - n_plus_h;
      case (state_ff)
         S_IDLE: begin
            // no transfer while the result strobe is out (busy still high)
            if (start && !done_ff) begin
               req_in   = req_item;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.op   = OP_MATCH;
            state_in = S_PICK;
         end
         S_PICK: begin
            sel_in   = hit;
            found_in = seen_c[N];
            state_in = S_ACT;
         end
         S_ACT: begin
            rsp_in.block_offset = '0;
            if (req_ff.mode == MODE_ALLOC) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
               if (found_ff && sb_ext == n_req) begin
                  cmd.op              = OP_USE;
                  rsp_in.status       = ST_OK;
                  rsp_in.block_offset = s_start[11:0];
               end else if (found_ff && sb_ext > n_plus_h &&
                            count_ff != CNT_W'(MAX_ENTRIES)) begin
                  cmd.op              = OP_SPLIT;
                  count_in            = count_ff + 1'b1;
                  rsp_in.status       = ST_OK;
                  rsp_in.block_offset = s_start[11:0];
               end else if (found_ff && sb_ext > n_plus_h) begin
                  rsp_in.status = ST_NOFIT;
               end else if (n_req > CW'(POOL_BYTES - HEADER_BYTES)) begin
                  rsp_in.status = ST_OVER;
               end else begin
                  rsp_in.status = ST_NOFIT;
               end
            end else if (addr_bad) begin
               rsp_in.status = ST_BADADDR;
               done_in       = 1'b1;
               state_in      = S_IDLE;
            end else if (s_free) begin
               rsp_in.status = ST_DOUBLE;
               done_in       = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.op        = OP_RELEASE;
               rsp_in.status = ST_OK;
               state_in      = S_PREV;
            end
         end
         S_PREV: begin
            // merge with previous neighbor: move the selection down first
            if (!sel_ff[0] && pv_free) begin
               sel_in   = sel_ff >> 1;
               state_in = S_JOINP;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_JOINP: begin
            cmd.op   = OP_JOIN;
            count_in = count_ff - 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (nx_valid && nx_free) begin
               cmd.op   = OP_JOIN;
               count_in = count_ff - 1'b1;
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CNT_W'(1);
         done_ff  <= 1'b0;
         sel_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         sel_ff   <= sel_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // busy covers the result cycle too, so the next transfer follows it
   assign busy      = (state_ff != S_IDLE) || done_ff;
   assign rsp_valid = done_ff;
   assign rsp_item  = rsp_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_W'(MAX_ENTRIES)))
      else $error("entry count out of range");

   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_ff))
      else $error("selection not one-hot");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   a_ok_alloc_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACT && req_ff.mode == MODE_ALLOC && cmd.op == OP_SPLIT)
      |-> found_ff)
      else $error("split without a hit");

endmodule
